// ===== sv/well512_generator_macros.svh =====
// ============================================================================
// WELL512 generator assertion macros
// Shared property templates for the concurrent checks in the RTL.
// ============================================================================
`ifndef WELL512_GENERATOR_MACROS_SVH
`define WELL512_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while the synchronous reset is low.
`define WL512_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while the synchronous reset is low.
`define WL512_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/wl512_pkg.sv =====
// ============================================================================
// WELL512 package
// Types and fixed constants shared by the WELL512 generator modules.
// ============================================================================
`timescale 1ns / 1ps

package wl512_pkg;

    localparam int unsigned POOL_DEPTH = 16;
    localparam int unsigned ADDR_W     = $clog2(POOL_DEPTH);
    localparam int unsigned WORD_W     = 32;

    // Low 32 bits of the LCG multiplier; the upper bits never reach a 32-bit result.
    localparam logic [WORD_W-1:0] LCG_MUL_LO  = 32'hDEEC_E66D;
    localparam logic [WORD_W-1:0] LCG_INC     = 32'h0000_000B;
    localparam logic [WORD_W-1:0] TEMPER_MASK = 32'hDA44_2D24;

    // Pool offsets relative to the current position.
    localparam logic [ADDR_W-1:0] OFF_B  = 4'd13;
    localparam logic [ADDR_W-1:0] OFF_C  = 4'd9;
    localparam logic [ADDR_W-1:0] OFF_Z0 = 4'd15;

    localparam logic [ADDR_W-1:0] ADDR_FIRST = 4'd0;
    localparam logic [ADDR_W-1:0] ADDR_SECOND = 4'd1;
    localparam logic [ADDR_W-1:0] ADDR_LAST = 4'd15;

    // Kind of transaction.
    localparam logic KIND_SEED = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_SEED_W0  = 8'b0000_0010,
        ST_SEED_W1  = 8'b0000_0100,
        ST_SEED_MUL = 8'b0000_1000,
        ST_SEED_ADD = 8'b0001_0000,
        ST_DRAW_B   = 8'b0010_0000,
        ST_DRAW_C   = 8'b0100_0000,
        ST_DRAW_D   = 8'b1000_0000
    } t_state;

    // Control word for the shared LCG unit.
    typedef struct packed {
        logic load;   // take a fresh seed
        logic mul;    // register t times the multiplier
        logic add;    // register product plus increment into t
        logic first;  // increment is the low seed half instead of the constant
    } t_lcg_ctrl;

endpackage

// ===== sv/wl512_pool.sv =====
// ============================================================================
// WELL512 state pool
// Sixteen-word memory with one write port, two registered read ports and
// per-entry valid bits so that unwritten entries read as zero after reset.
// ============================================================================
`timescale 1ns / 1ps

module wl512_pool (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_we,
    input  logic [wl512_pkg::ADDR_W-1:0]        i_waddr,
    input  logic [wl512_pkg::WORD_W-1:0]        i_wdata,
    input  logic [wl512_pkg::ADDR_W-1:0]        i_raddr0,
    input  logic [wl512_pkg::ADDR_W-1:0]        i_raddr1,
    output logic [wl512_pkg::WORD_W-1:0]        o_rdata0,
    output logic [wl512_pkg::WORD_W-1:0]        o_rdata1
);
    import wl512_pkg::*;

    logic [WORD_W-1:0]     r_mem [POOL_DEPTH];
    logic [POOL_DEPTH-1:0] r_valid;
    logic [WORD_W-1:0]     r_rd0;
    logic [WORD_W-1:0]     r_rd1;
    logic                  r_rv0;
    logic                  r_rv1;

    // Memory write and registered reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd0 <= r_mem[i_raddr0];
        r_rd1 <= r_mem[i_raddr1];
    end

    // Valid bits and their registered copies for the read ports.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rv0   <= 1'b0;
            r_rv1   <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rv0 <= r_valid[i_raddr0];
            r_rv1 <= r_valid[i_raddr1];
        end
    end

    // An entry never written since reset reads as zero.
    assign o_rdata0 = r_rv0 ? r_rd0 : '0;
    assign o_rdata1 = r_rv1 ? r_rd1 : '0;

endmodule

// ===== sv/wl512_lcg.sv =====
// ============================================================================
// WELL512 seeding LCG unit
// Shared multiplier and adder that walk the linear congruential fill,
// one multiply and one add per step.
// ============================================================================
`timescale 1ns / 1ps

module wl512_lcg (
    input  logic                                i_clk,
    input  wl512_pkg::t_lcg_ctrl                i_ctrl,
    input  logic [2*wl512_pkg::WORD_W-1:0]      i_seed,
    output logic [wl512_pkg::WORD_W-1:0]        o_t,
    output logic [wl512_pkg::WORD_W-1:0]        o_lo,
    output logic [wl512_pkg::WORD_W-1:0]        o_sum
);
    import wl512_pkg::*;

    logic [WORD_W-1:0] r_t;
    logic [WORD_W-1:0] r_lo;
    logic [WORD_W-1:0] r_prod;

    // Sum of the registered product and the current increment.
    assign o_sum = r_prod + (i_ctrl.first ? r_lo : LCG_INC);

    // Datapath registers; the product is registered before the add.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_t  <= i_seed[2*WORD_W-1:WORD_W];
            r_lo <= i_seed[WORD_W-1:0];
        end else if (i_ctrl.add) begin
            r_t <= o_sum;
        end
        if (i_ctrl.mul) begin
            r_prod <= r_t * LCG_MUL_LO;
        end
    end

    assign o_t  = r_t;
    assign o_lo = r_lo;

endmodule

// ===== sv/well512_generator.sv =====
// ============================================================================
// WELL512a generator
// Seeds a sixteen-word pool through an LCG fill and draws 32-bit words
// with the WELL512a recurrence, one transaction at a time.
// ============================================================================
//  Channel   Handshake          Payload            Direction
//  command   start / busy       i_kind, i_seed     in
//  result    o_valid strobe     o_word             out
//
// A draw keeps busy high through the ST_DRAW_B, ST_DRAW_C and ST_DRAW_D states
// and shows its word in the cycle after ST_DRAW_D. It reads the pool twice on
// the two read ports and writes it twice through its single write port.
// A seed keeps busy high through two pool writes and then fifteen multiply
// and add steps through the shared LCG unit (the first one folds in the
// low seed half), and gives no result.
// Reset is synchronous and active low; the pool reads as zero until seeded.
// The receiver cannot stall: o_valid is high for exactly one cycle.
`timescale 1ns / 1ps

module well512_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_kind,
    input  logic [2*wl512_pkg::WORD_W-1:0]      i_seed,
    output logic                                o_valid,
    output logic [wl512_pkg::WORD_W-1:0]        o_word
);
    import wl512_pkg::*;

    t_state               r_state;
    t_state               n_state;
    logic [ADDR_W-1:0]    r_pos;
    logic [ADDR_W-1:0]    r_k;
    logic [WORD_W-1:0]    r_z1;
    logic [WORD_W-1:0]    r_n0;
    logic [WORD_W-1:0]    r_word;
    logic                 r_valid;

    logic                 accept;
    t_lcg_ctrl            lcg_ctrl;
    logic [WORD_W-1:0]    lcg_t;
    logic [WORD_W-1:0]    lcg_lo;
    logic [WORD_W-1:0]    lcg_sum;

    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [WORD_W-1:0]    mem_wdata;
    logic [ADDR_W-1:0]    mem_raddr0;
    logic [ADDR_W-1:0]    mem_raddr1;
    logic [WORD_W-1:0]    mem_rdata0;
    logic [WORD_W-1:0]    mem_rdata1;

    logic [WORD_W-1:0]    a_w;
    logic [WORD_W-1:0]    b_w;
    logic [WORD_W-1:0]    z1;
    logic [WORD_W-1:0]    z2;
    logic [WORD_W-1:0]    n1;
    logic [WORD_W-1:0]    n0;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_kind == KIND_DRAW) ? ST_DRAW_B : ST_SEED_W0;
                end
            end
            ST_SEED_W0:  n_state = ST_SEED_W1;
            ST_SEED_W1:  n_state = ST_SEED_MUL;
            ST_SEED_MUL: n_state = ST_SEED_ADD;
            ST_SEED_ADD: n_state = (r_k == ADDR_LAST) ? ST_IDLE : ST_SEED_MUL;
            ST_DRAW_B:   n_state = ST_DRAW_C;
            ST_DRAW_C:   n_state = ST_DRAW_D;
            ST_DRAW_D:   n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // LCG unit control.
    always_comb begin
        lcg_ctrl.load  = accept && (i_kind == KIND_SEED);
        lcg_ctrl.mul   = (r_state == ST_SEED_MUL);
        lcg_ctrl.add   = (r_state == ST_SEED_ADD);
        lcg_ctrl.first = (r_k == ADDR_SECOND);
    end

    wl512_lcg u_lcg (
        .i_clk  (i_clk),
        .i_ctrl (lcg_ctrl),
        .i_seed (i_seed),
        .o_t    (lcg_t),
        .o_lo   (lcg_lo),
        .o_sum  (lcg_sum)
    );

    // Recurrence terms; pool data arrive in the cycle after their addresses.
    assign a_w = mem_rdata0;
    assign b_w = mem_rdata1;
    assign z1  = (a_w ^ (a_w << 16)) ^ (b_w ^ (b_w << 15));
    assign z2  = mem_rdata0 ^ (mem_rdata0 >> 11);
    assign n1  = r_z1 ^ z2;
    assign n0  = (mem_rdata1 ^ (mem_rdata1 << 2)) ^ (r_z1 ^ (r_z1 << 18))
               ^ (z2 << 28) ^ (n1 ^ ((n1 << 5) & TEMPER_MASK));

    // Read addresses: c and z0 in the ST_DRAW_B state, a and b in every other state.
    always_comb begin
        if (r_state == ST_DRAW_B) begin
            mem_raddr0 = ADDR_W'(r_pos + OFF_C);
            mem_raddr1 = ADDR_W'(r_pos + OFF_Z0);
        end else begin
            mem_raddr0 = r_pos;
            mem_raddr1 = ADDR_W'(r_pos + OFF_B);
        end
    end

    // Write port selection.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_pos;
        mem_wdata = n1;
        unique case (r_state)
            ST_SEED_W0: begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_FIRST;
                mem_wdata = lcg_t;
            end
            ST_SEED_W1: begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_SECOND;
                mem_wdata = lcg_lo;
            end
            ST_SEED_ADD: begin
                mem_we    = (r_k != ADDR_SECOND);
                mem_waddr = r_k;
                mem_wdata = lcg_sum;
            end
            ST_DRAW_C: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                mem_wdata = n1;
            end
            ST_DRAW_D: begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(r_pos + OFF_Z0);
                mem_wdata = r_n0;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    wl512_pool u_pool (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (mem_we),
        .i_waddr  (mem_waddr),
        .i_wdata  (mem_wdata),
        .i_raddr0 (mem_raddr0),
        .i_raddr1 (mem_raddr1),
        .o_rdata0 (mem_rdata0),
        .o_rdata1 (mem_rdata1)
    );

    // Control registers: state, position, fill counter and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
            r_k     <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_DRAW_D);
            if (accept && (i_kind == KIND_SEED)) begin
                r_pos <= '0;
                r_k   <= ADDR_SECOND;
            end else if (r_state == ST_SEED_ADD) begin
                r_k <= ADDR_W'(r_k + 1'b1);
            end else if (r_state == ST_DRAW_D) begin
                r_pos <= ADDR_W'(r_pos + OFF_Z0);
            end
        end
    end

    // Payload registers of the draw.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DRAW_B) begin
            r_z1 <= z1;
        end
        if (r_state == ST_DRAW_C) begin
            r_n0 <= n0;
        end
        if (r_state == ST_DRAW_D) begin
            r_word <= r_n0;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

    // Checks on the sequencer.
    `include "well512_generator_macros.svh"

    `WL512_ASSERT_NXT(a_draw_advances, i_clk, i_rst_n, (r_state == ST_DRAW_D), (o_valid && (r_pos == ADDR_W'($past(r_pos) + OFF_Z0))), "draw did not strobe a result and advance the position")
    `WL512_ASSERT_IMP(a_valid_when_idle, i_clk, i_rst_n, o_valid, (r_state == ST_IDLE), "result strobe while the sequencer is busy")
    `WL512_ASSERT_NXT(a_seed_no_result, i_clk, i_rst_n, ((r_state == ST_SEED_ADD) && (r_k == ADDR_LAST)), ((r_state == ST_IDLE) && !o_valid), "seed fill did not end quietly")

endmodule

// ===== tb/tb_well512_generator.sv =====
// ============================================================================
// WELL512a generator testbench
// Drives seed and draw transactions with bursty timing and predicts every
// drawn word with a local copy of the pool, its position and the LCG fill.
// ============================================================================
`timescale 1ns / 1ps

module tb_well512_generator;

    import wl512_pkg::*;

    localparam int unsigned     CLK_HALF     = 2;
    localparam int unsigned     RESET_CYCLES = 11;
    localparam int unsigned     ITEM_TARGET  = 800;
    localparam int unsigned     CYCLE_LIMIT  = 400000;
    localparam int unsigned     QUIET_CYCLES = 16;
    localparam int unsigned     REPORT_MAX   = 10;
    localparam logic [63:0]     LCG_MUL      = 64'h0000_0005_DEEC_E66D;
    localparam logic [63:0]     LCG_STEP_INC = 64'h0000_0000_0000_000B;
    localparam logic [31:0]     MIX_MASK     = 32'hDA44_2D24;

    // One pending command transaction; hold_off makes the driver wait for
    // every outstanding word before presenting it.
    typedef struct {
        logic        kind;
        logic [63:0] seed;
        bit          hold_off;
    } gen_cmd_t;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        i_kind  = 1'b0;
    logic [63:0] i_seed  = 64'd0;
    logic        busy;
    logic        o_valid;
    logic [31:0] o_word;

    gen_cmd_t    cmd_queue[$];
    logic [31:0] word_fifo[$];

    // Predicted generator state.
    logic [31:0] pool_words[16];
    logic [3:0]  pool_pos;

    int unsigned words_waiting = 0;
    int unsigned fail_cnt      = 0;
    int unsigned cycle_cnt     = 0;
    int unsigned seed_cnt      = 0;
    int unsigned draw_cnt      = 0;
    int unsigned word_cnt      = 0;
    int unsigned hold_cnt      = 0;
    int unsigned burst_left    = 1;
    int unsigned gap_left      = 0;

    well512_generator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_kind  (i_kind),
        .i_seed  (i_seed),
        .o_valid (o_valid),
        .o_word  (o_word)
    );

    // Clock.
    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // One linear congruential step, low 32 bits of x * multiplier + inc.
    function automatic logic [31:0] lcg_next(logic [31:0] x, logic [63:0] inc);
        logic [63:0] prod;
        prod = {32'd0, x} * LCG_MUL + inc;
        return prod[31:0];
    endfunction

    // Seeding: both halves of the seed go in first, the rest of the pool
    // comes from the LCG chain, and the position restarts at zero.
    task automatic load_pool_seed(logic [63:0] s);
        logic [31:0] t;
        pool_pos      = 4'd0;
        pool_words[0] = s[63:32];
        pool_words[1] = s[31:0];
        t = lcg_next(s[63:32], {32'd0, s[31:0]});
        for (int k = 2; k < 16; k++) begin
            t = lcg_next(t, LCG_STEP_INC);
            pool_words[k] = t;
        end
    endtask

    // One step of the WELL512a recurrence; returns the word at the new position.
    function automatic logic [31:0] well_draw();
        logic [3:0]  idx_b;
        logic [3:0]  idx_c;
        logic [3:0]  idx_z;
        logic [31:0] a, b, c, z0, z1, z2, n1, n0;
        idx_b = pool_pos + 4'd13;
        idx_c = pool_pos + 4'd9;
        idx_z = pool_pos + 4'd15;
        a  = pool_words[pool_pos];
        b  = pool_words[idx_b];
        c  = pool_words[idx_c];
        z0 = pool_words[idx_z];
        z1 = (a ^ (a << 16)) ^ (b ^ (b << 15));
        z2 = c ^ (c >> 11);
        n1 = z1 ^ z2;
        pool_words[pool_pos] = n1;
        n0 = (z0 ^ (z0 << 2)) ^ (z1 ^ (z1 << 18)) ^ (z2 << 28)
             ^ (n1 ^ ((n1 << 5) & MIX_MASK));
        pool_words[idx_z] = n0;
        pool_pos = idx_z;
        return pool_words[pool_pos];
    endfunction

    task automatic push_cmd(logic kind, logic [63:0] seed, bit hold_off);
        gen_cmd_t c;
        c.kind     = kind;
        c.seed     = seed;
        c.hold_off = hold_off;
        cmd_queue.push_back(c);
    endtask

    function automatic logic [63:0] rand_seed();
        return {$urandom, $urandom};
    endfunction

    // Driver: bursts of transactions separated by random gaps.
    always @(posedge i_clk) begin
        gen_cmd_t cur;
        bit       taken;
        bit       present;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            taken   = start && !busy;
            present = 1'b0;
            if (taken) begin
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    // Now and then a long stretch with no gaps at all.
                    if ($urandom_range(0, 5) == 0) begin
                        gap_left   = 0;
                        burst_left = $urandom_range(30, 80);
                    end else begin
                        gap_left   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
                        burst_left = $urandom_range(1, 24);
                    end
                end
            end
            if (start && !taken) begin
                // Holding the current transaction until it is taken.
                present = 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (cmd_queue.size() != 0) begin
                if (!cmd_queue[0].hold_off || (!taken && words_waiting == 0 && !busy))
                    present = 1'b1;
            end
            if (start && !taken) begin
                start <= 1'b1;
            end else if (present) begin
                cur = cmd_queue.pop_front();
                if (cur.hold_off) hold_cnt++;
                start  <= 1'b1;
                i_kind <= cur.kind;
                i_seed <= cur.seed;
            end else begin
                // Idle: payload carries noise that must be ignored.
                start  <= 1'b0;
                i_kind <= $urandom_range(0, 1);
                i_seed <= rand_seed();
            end
        end
    end

    task automatic note_failure(string what, logic [31:0] exp_w, logic [31:0] act_w);
        fail_cnt++;
        if (fail_cnt <= REPORT_MAX)
            $display("[%0t] %s: expected %08h, got %08h", $realtime, what, exp_w, act_w);
    endtask

    // Monitor: checks each result word, then predicts for a new transaction.
    always @(posedge i_clk) begin
        logic [31:0] exp_w;
        if (i_rst_n) begin
            if (o_valid) begin
                word_cnt++;
                if (word_fifo.size() == 0) begin
                    note_failure("unexpected word", 32'd0, o_word);
                end else begin
                    exp_w = word_fifo.pop_front();
                    if (o_word !== exp_w) note_failure("word mismatch", exp_w, o_word);
                end
            end
            if (start && !busy) begin
                if (i_kind == KIND_DRAW) begin
                    word_fifo.push_back(well_draw());
                    draw_cnt++;
                end else begin
                    load_pool_seed(i_seed);
                    seed_cnt++;
                end
            end
            words_waiting <= word_fifo.size();
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Run limit reached after %0d cycles", cycle_cnt);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int unsigned n;
        int unsigned run_len;
        logic [63:0] s;
        for (int k = 0; k < 16; k++) pool_words[k] = 32'd0;
        pool_pos = 4'd0;

        // Draws before any seed run on the all-zero pool.
        repeat (3) push_cmd(KIND_DRAW, rand_seed(), 1'b0);
        // Extreme seeds, each followed by one or more draws.
        push_cmd(KIND_SEED, 64'd0, 1'b1);
        repeat (2) push_cmd(KIND_DRAW, 64'd0, 1'b0);
        push_cmd(KIND_SEED, {64{1'b1}}, 1'b0);
        repeat (4) push_cmd(KIND_DRAW, {64{1'b1}}, 1'b0);
        push_cmd(KIND_SEED, 64'hFFFF_FFFF_0000_0000, 1'b0);
        push_cmd(KIND_DRAW, 64'd0, 1'b0);
        push_cmd(KIND_SEED, 64'h0000_0000_FFFF_FFFF, 1'b0);
        push_cmd(KIND_DRAW, 64'd0, 1'b0);
        // Seed field must not matter on a draw.
        push_cmd(KIND_SEED, 64'h8000_0000_0000_0001, 1'b0);
        push_cmd(KIND_DRAW, {64{1'b1}}, 1'b0);
        push_cmd(KIND_DRAW, 64'd0, 1'b0);
        push_cmd(KIND_DRAW, rand_seed(), 1'b0);
        // Back-to-back seeds: only the second one counts.
        push_cmd(KIND_SEED, 64'h0123_4567_89AB_CDEF, 1'b0);
        push_cmd(KIND_SEED, 64'hA5A5_A5A5_5A5A_5A5A, 1'b0);
        repeat (2) push_cmd(KIND_DRAW, rand_seed(), 1'b0);

        // Random part: mostly a seed followed by a run of draws.
        n = cmd_queue.size();
        while (n < ITEM_TARGET) begin
            case ($urandom_range(0, 7))
                0:       s = {$urandom, 32'd0};
                1:       s = {32'hFFFF_FFFF, $urandom};
                default: s = rand_seed();
            endcase
            push_cmd(KIND_SEED, s, (n >= 300 && n < 330) || (n >= 600 && n < 630));
            n++;
            run_len = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 40);
            for (int k = 0; k < run_len; k++) begin
                push_cmd(KIND_DRAW, rand_seed(), $urandom_range(0, 150) == 0);
                n++;
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || start || busy || words_waiting != 0)
            @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);

        if (word_fifo.size() != 0) begin
            $display("%0d predicted words never appeared", word_fifo.size());
            fail_cnt += word_fifo.size();
        end
        $display("Covered %0d seed and %0d draw transactions, %0d words checked,",
                 seed_cnt, draw_cnt, word_cnt);
        $display("%0d drain pauses, %0d failures in %0d cycles.", hold_cnt, fail_cnt, cycle_cnt);
        if (fail_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/wl512_pkg.sv
sv/wl512_pool.sv
sv/wl512_lcg.sv
sv/well512_generator.sv
tb/tb_well512_generator.sv
